// ===== sv/sldf_pkg.sv =====
// ============================================================================
// sldf_pkg
// Shared types, constants and arithmetic helpers of the scheduled LED dimmer.
// ============================================================================
package sldf_pkg;

    // LED channels and table geometry
    localparam int CHANNELS   = 5;
    localparam int HOURS      = 24;
    localparam int MANUAL_ROW = 24;
    localparam int ROWS       = 25;
    localparam int CH_W       = 3;                 // width of the entry_channel field
    localparam int ROW_W      = 5;                 // width of the row / hour fields
    localparam int ADDR_W     = ROW_W + CH_W;
    localparam int MEM_DEPTH  = ROWS * (2 ** CH_W);
    localparam int OUT_CH_W   = 4;
    localparam int PCT_W      = 7;
    localparam int PWM_W      = 11;
    localparam int VAL_W      = 8;
    localparam int SECS_W     = 12;
    localparam int SUM_W      = 10;
    localparam int PCT_FULL   = 100;

    // item kinds carried in tuser
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_WRITE   = 2'd1;
    localparam logic [1:0] MODE_PREVIEW = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SCHEDULE_ENABLE = 2'd0;
    localparam logic [1:0] CFG_FAN_AUTO        = 2'd1;
    localparam logic [1:0] CFG_FAN_THRESHOLD   = 2'd2;
    localparam logic [1:0] CFG_FAN_FIXED_POWER = 2'd3;

    // floor(y / 225) for y < 2**16 as (y * DIV225_RECIP) >> 25
    localparam logic [17:0] DIV225_RECIP = 18'd149131;
    // floor(p * 1024 / 100) for p <= 100 as (p * PWM_RECIP) >> 12
    localparam logic [15:0] PWM_RECIP    = 16'd41944;
    // floor(s / CHANNELS) for s < 2**10 as (s * FAN_RECIP) >> 20
    localparam int          FAN_RECIP_I  = (2 ** 20 + CHANNELS - 1) / CHANNELS;
    localparam logic [20:0] FAN_RECIP    = 21'(FAN_RECIP_I);

    typedef logic [PCT_W-1:0] t_pct;
    typedef logic [PWM_W-1:0] t_pwm;

    function automatic t_pwm pwm_of(input t_pct pct);
        logic [PCT_W+15:0] prod;
        begin
            prod = {16'd0, pct} * {{PCT_W{1'b0}}, PWM_RECIP};
            return prod[PWM_W+11:12];
        end
    endfunction

    function automatic t_pct clamp_pct(input logic [9:0] v);
        begin
            return (v > 10'(PCT_FULL)) ? PCT_W'(PCT_FULL) : v[PCT_W-1:0];
        end
    endfunction

endpackage

// ===== sv/scheduled_led_dimmer_with_fan_top.sv =====
// ============================================================================
// scheduled_led_dimmer_with_fan_top
// Hourly scheduled / manual LED dimmer with fan duty output.
// ============================================================================
// A tick item (tuser = tick) produces one result per LED channel, 0 up to
// CHANNELS-1, followed by the fan result carrying tlast. Table-write and
// preview-start items produce no result, and a schedule tick without valid
// time and outside a preview run is dropped. The brightness table sits in a
// single synchronous memory (25 rows by 8 channel slots) with two read ports,
// so the entries of this hour and the next hour are fetched together. Each
// channel walks a five-step sequence: read, difference times seconds,
// reciprocal divide by 3600, clamp and accumulate, emit. After the last
// channel a fan step loads the fan result, and each emit waits while the
// output is stalled. Writes and preview starts leave the sequencer idle, and
// the input of the block accepts items only while no tick is
// in progress, which also keeps table writes away from table reads; the last
// result of a tick may still wait in the output register while the next item
// is taken. The table needs no clearing pass: a per-entry valid flag makes
// entries never written read as zero. Configuration writes are always ready.
// ============================================================================
module scheduled_led_dimmer_with_fan_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // in item: [0] time_valid, [5:1] clock_hour, [11:6] clock_minute,
    // [17:12] clock_second, [22:18] entry_row, [25:23] entry_channel,
    // [33:26] entry_value, [39:34] zero
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    // out item: [3:0] out_channel, [10:4] percent, [21:11] pwm_level, [23:22] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,   // last
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data
);
    import sldf_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_VAL  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;
    localparam logic [2:0] S_FAN  = 3'd6;

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic              w_tv;
    logic [ROW_W-1:0]  w_hour;
    logic [5:0]        w_min;
    logic [5:0]        w_sec;
    logic [ROW_W-1:0]  w_row;
    logic [CH_W-1:0]   w_ech;
    logic [VAL_W-1:0]  w_val;
    logic [1:0]        w_mode;
    logic              w_in_acc;

    assign w_tv   = s_axis_tdata[0];
    assign w_hour = s_axis_tdata[5:1];
    assign w_min  = s_axis_tdata[11:6];
    assign w_sec  = s_axis_tdata[17:12];
    assign w_row  = s_axis_tdata[22:18];
    assign w_ech  = s_axis_tdata[25:23];
    assign w_val  = s_axis_tdata[33:26];
    assign w_mode = s_axis_tuser;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic              r_sched_en;
    logic              r_fan_auto;
    logic [SUM_W-1:0]  r_fan_thr;
    logic [PCT_W-1:0]  r_fan_fixed;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sched_en  <= 1'b0;
            r_fan_auto  <= 1'b0;
            r_fan_thr   <= '0;
            r_fan_fixed <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SCHEDULE_ENABLE: r_sched_en  <= i_cfg_data[0];
                CFG_FAN_AUTO:        r_fan_auto  <= i_cfg_data[0];
                CFG_FAN_THRESHOLD:   r_fan_thr   <= i_cfg_data;
                CFG_FAN_FIXED_POWER: r_fan_fixed <= i_cfg_data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    logic [2:0]          r_state;
    logic [OUT_CH_W-1:0] r_ch;
    logic [ROW_W-1:0]    r_cur;
    logic [ROW_W-1:0]    r_nxt;
    logic                r_full;
    logic [SECS_W-1:0]   r_secs;
    logic                r_prev_act;
    logic [ROW_W-1:0]    r_prev_hour;
    logic [VAL_W-1:0]    r_a;
    logic [VAL_W-1:0]    r_d;
    logic                r_up;
    logic                r_down;
    logic [19:0]         r_prod;
    logic [8:0]          r_step;
    logic [PCT_W-1:0]    r_pct;
    logic [SUM_W-1:0]    r_sum;

    // output register
    logic                r_out_valid;
    logic [OUT_CH_W-1:0] r_out_ch;
    logic [PCT_W-1:0]    r_out_pct;
    logic [PWM_W-1:0]    r_out_pwm;
    logic                r_out_last;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Brightness table: one write port, two registered read ports
    // ------------------------------------------------------------------
    logic [VAL_W-1:0]     r_mem [0:MEM_DEPTH-1];
    logic [MEM_DEPTH-1:0] r_mem_vld;
    logic [VAL_W-1:0]     r_rd_a;
    logic [VAL_W-1:0]     r_rd_b;
    logic                 r_vld_a;
    logic                 r_vld_b;
    logic                 w_we;
    logic [ADDR_W-1:0]    w_waddr;
    logic [ADDR_W-1:0]    w_raddr_a;
    logic [ADDR_W-1:0]    w_raddr_b;

    assign w_we      = w_in_acc && (w_mode == MODE_WRITE) && (w_row < ROW_W'(ROWS))
                       && ({1'b0, w_ech} < 4'(CHANNELS));
    assign w_waddr   = {w_row, w_ech};
    assign w_raddr_a = {r_cur, r_ch[CH_W-1:0]};
    assign w_raddr_b = {r_nxt, r_ch[CH_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_val;
        end
        r_rd_a <= r_mem[w_raddr_a];
        r_rd_b <= r_mem[w_raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
            r_vld_a   <= 1'b0;
            r_vld_b   <= 1'b0;
        end else begin
            if (w_we) begin
                r_mem_vld[w_waddr] <= 1'b1;
            end
            r_vld_a <= r_mem_vld[w_raddr_a];
            r_vld_b <= r_mem_vld[w_raddr_b];
        end
    end

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic [VAL_W-1:0]  w_a;
    logic [VAL_W-1:0]  w_b;
    logic [VAL_W-1:0]  w_d;
    logic [ROW_W-1:0]  w_clk_hour;
    logic [ROW_W-1:0]  w_prev_cur;
    logic [SECS_W-1:0] w_secs;
    logic [33:0]       w_div_prod;
    logic [9:0]        w_v;
    logic [PCT_W-1:0]  w_v_pct;
    logic [30:0]       w_fan_prod;
    logic [10:0]       w_fan_avg;
    logic [PCT_W-1:0]  w_fan_pct;
    logic              w_out_free;

    // never-written entries read as zero
    assign w_a = r_vld_a ? r_rd_a : '0;
    assign w_b = r_vld_b ? r_rd_b : '0;
    assign w_d = (w_b > w_a) ? (w_b - w_a) : (w_a - w_b);

    // wrap hours 24..31 back into the day
    assign w_clk_hour = (w_hour >= ROW_W'(HOURS)) ? (w_hour - ROW_W'(HOURS)) : w_hour;
    assign w_prev_cur = (r_prev_hour >= ROW_W'(HOURS - 1)) ? ROW_W'(HOURS - 1) : r_prev_hour;
    // minute*60 + second as minute*64 - minute*4 + second
    assign w_secs = {w_min, 6'd0} - {4'd0, w_min, 2'd0} + {6'd0, w_sec};

    // divide by 3600: drop four bits, then reciprocal of 225
    assign w_div_prod = {18'd0, r_prod[19:4]} * {16'd0, DIV225_RECIP};

    always_comb begin
        if (r_up) begin
            w_v = {2'd0, r_a} + {1'b0, r_step};
        end else if (r_down) begin
            w_v = ({1'b0, r_step} >= {2'd0, r_a}) ? 10'd0 : ({2'd0, r_a} - {1'b0, r_step});
        end else begin
            w_v = {2'd0, r_a};
        end
    end
    assign w_v_pct = clamp_pct(w_v);

    assign w_fan_prod = {21'd0, r_sum} * {10'd0, FAN_RECIP};
    assign w_fan_avg  = w_fan_prod[30:20];

    always_comb begin
        if (r_fan_auto) begin
            w_fan_pct = (r_sum > r_fan_thr) ? clamp_pct(w_fan_avg[9:0]) : '0;
        end else begin
            w_fan_pct = clamp_pct({3'd0, r_fan_fixed});
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    // ------------------------------------------------------------------
    // Sequencer: one channel at a time through the table memory
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev_act  <= 1'b0;
            r_prev_hour <= '0;
            r_ch        <= '0;
            r_sum       <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_ch   <= '0;
                        r_sum  <= '0;
                        r_secs <= w_secs;
                        case (w_mode)
                            MODE_PREVIEW: begin
                                r_prev_act  <= 1'b1;
                                r_prev_hour <= '0;
                            end
                            MODE_TICK: begin
                                if (!r_sched_en) begin
                                    // manual row on both ports: zero delta
                                    r_cur   <= ROW_W'(MANUAL_ROW);
                                    r_nxt   <= ROW_W'(MANUAL_ROW);
                                    r_full  <= 1'b1;
                                    r_state <= S_RD;
                                end else if (r_prev_act) begin
                                    r_cur   <= w_prev_cur;
                                    r_nxt   <= (w_prev_cur == ROW_W'(HOURS - 1)) ? '0
                                               : w_prev_cur + 1'b1;
                                    r_full  <= 1'b1;
                                    r_state <= S_RD;
                                    if (w_prev_cur == ROW_W'(HOURS - 1)) begin
                                        r_prev_act  <= 1'b0;
                                        r_prev_hour <= '0;
                                    end else begin
                                        r_prev_hour <= w_prev_cur + 1'b1;
                                    end
                                end else if (w_tv) begin
                                    r_cur   <= w_clk_hour;
                                    r_nxt   <= (w_clk_hour == ROW_W'(HOURS - 1)) ? '0
                                               : w_clk_hour + 1'b1;
                                    r_full  <= 1'b0;
                                    r_state <= S_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: begin
                    // memory read in flight
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_a     <= w_a;
                    r_d     <= w_d;
                    r_up    <= (w_b > w_a);
                    r_down  <= (w_b < w_a);
                    r_prod  <= {12'd0, w_d} * {8'd0, r_secs};
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step  <= r_full ? {1'b0, r_d} : w_div_prod[33:25];
                    r_state <= S_VAL;
                end
                S_VAL: begin
                    r_pct   <= w_v_pct;
                    r_sum   <= r_sum + {3'd0, w_v_pct};
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        if (r_ch == OUT_CH_W'(CHANNELS)) begin
                            r_state <= S_IDLE;
                        end else if (r_ch == OUT_CH_W'(CHANNELS - 1)) begin
                            r_state <= S_FAN;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_FAN: begin
                    r_pct   <= w_fan_pct;
                    r_ch    <= OUT_CH_W'(CHANNELS);
                    r_state <= S_EMIT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Output register: load on emit, drop when taken
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_out_free) begin
            r_out_ch   <= r_ch;
            r_out_pct  <= r_pct;
            r_out_pwm  <= pwm_of(r_pct);
            r_out_last <= (r_ch == OUT_CH_W'(CHANNELS));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'd0, r_out_pwm, r_out_pct, r_out_ch};
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the run closes on the fan result and only there
    a_last_is_fan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[3:0] == OUT_CH_W'(CHANNELS))))
        else $error("tlast does not match fan channel");

    // percent never exceeds full scale
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[10:4] <= PCT_W'(PCT_FULL)))
        else $error("percent above 100");

    // writes and preview starts never start a channel walk
    a_no_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_mode != MODE_TICK) |=> (r_state == S_IDLE))
        else $error("non-tick item started a walk");

endmodule

// ===== tb/scheduled_led_dimmer_with_fan_checker.sv =====
// ============================================================================
// scheduled_led_dimmer_with_fan_checker
// Predicts every LED and fan level from the accepted items and compares them
// with the results leaving the dimmer, field by field, in order.
// ============================================================================
module scheduled_led_dimmer_with_fan_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [39:0] i_in_data,
    input  logic [1:0]  i_in_kind,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,
    input  logic        i_out_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    output int          o_pending,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import sldf_pkg::*;

    typedef struct packed {
        logic [OUT_CH_W-1:0] chan;
        t_pct                pct;
        t_pwm                pwm;
        logic                last;
    } t_level;

    t_level      level_q[$];
    logic [7:0]  bright_tbl [0:ROWS-1][0:CHANNELS-1];
    logic        pv_active;
    logic [4:0]  pv_hour;
    logic        sched_en;
    logic        fan_auto;
    logic [9:0]  fan_thr;
    logic [6:0]  fan_fixed;
    int          fail_cnt;

    function automatic t_level make_level(input int chan, input int pct, input logic last);
        t_level r;
        r.chan = OUT_CH_W'(chan);
        r.pct  = PCT_W'(pct);
        r.pwm  = PWM_W'((pct * 1024) / PCT_FULL);
        r.last = last;
        return r;
    endfunction

    // a falling ramp driven past a full hour goes below zero
    function automatic int clamp_level(input int v);
        return (v < 0) ? 0 : ((v > PCT_FULL) ? PCT_FULL : v);
    endfunction

    // Update the table / preview state and queue the levels one item causes.
    task automatic predict_levels(input logic [1:0] kind, input logic [39:0] d);
        logic       tv;
        logic [4:0] hr;
        logic [5:0] mi;
        logic [5:0] se;
        logic [4:0] row;
        logic [2:0] ch;
        logic [7:0] val;
        logic [4:0] cur;
        logic [4:0] nxt;
        logic       full;
        logic       dropped;
        int         secs;
        int         a;
        int         b;
        int         dlt;
        int         stp;
        int         v;
        int         sum;
        int         fan;
        tv      = d[0];
        hr      = d[5:1];
        mi      = d[11:6];
        se      = d[17:12];
        row     = d[22:18];
        ch      = d[25:23];
        val     = d[33:26];
        sum     = 0;
        full    = 1'b0;
        dropped = 1'b0;
        cur     = '0;
        case (kind)
            MODE_WRITE: begin
                if (row < ROWS && ch < CHANNELS)
                    bright_tbl[row][ch] = val;
            end
            MODE_PREVIEW: begin
                pv_active = 1'b1;
                pv_hour   = '0;
            end
            MODE_TICK: begin
                if (!sched_en) begin
                    for (int i = 0; i < CHANNELS; i++) begin
                        v = clamp_level(bright_tbl[MANUAL_ROW][i]);
                        sum += v;
                        level_q.push_back(make_level(i, v, 1'b0));
                    end
                end else begin
                    if (pv_active) begin
                        cur  = pv_hour;
                        full = 1'b1;
                        if (cur >= HOURS - 1) begin
                            cur       = 5'(HOURS - 1);
                            pv_active = 1'b0;
                            pv_hour   = '0;
                        end else begin
                            pv_hour = cur + 5'd1;
                        end
                    end else if (!tv) begin
                        dropped = 1'b1;
                    end else begin
                        cur = (hr >= HOURS) ? hr - 5'(HOURS) : hr;
                    end
                    if (!dropped) begin
                        nxt  = (cur == HOURS - 1) ? 5'd0 : cur + 5'd1;
                        secs = int'(mi) * 60 + int'(se);
                        for (int i = 0; i < CHANNELS; i++) begin
                            a   = bright_tbl[cur][i];
                            b   = bright_tbl[nxt][i];
                            dlt = (b > a) ? b - a : a - b;
                            stp = full ? dlt : (dlt * secs) / 3600;
                            if (b > a)
                                v = a + stp;
                            else if (b < a)
                                v = a - stp;
                            else
                                v = a;
                            v = clamp_level(v);
                            sum += v;
                            level_q.push_back(make_level(i, v, 1'b0));
                        end
                    end
                end
                if (!dropped) begin
                    if (fan_auto)
                        fan = (sum > int'(fan_thr)) ? sum / CHANNELS : 0;
                    else
                        fan = fan_fixed;
                    level_q.push_back(make_level(CHANNELS, clamp_level(fan), 1'b1));
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(input string fname, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_level want;
        if (!i_rst_n) begin
            for (int r = 0; r < ROWS; r++)
                for (int c = 0; c < CHANNELS; c++)
                    bright_tbl[r][c] = '0;
            pv_active = 1'b0;
            pv_hour   = '0;
            sched_en  = 1'b0;
            fan_auto  = 1'b0;
            fan_thr   = '0;
            fan_fixed = '0;
            fail_cnt  = 0;
            level_q.delete();
        end else begin
            // compare the result first: a new item cannot produce one in the same cycle
            if (i_out_valid && i_out_ready) begin
                if (level_q.size() == 0) begin
                    $error("unexpected result: out_channel %0d percent %0d",
                           i_out_data[3:0], i_out_data[10:4]);
                    fail_cnt++;
                end else begin
                    want = level_q.pop_front();
                    check_field("out_channel", want.chan, i_out_data[3:0]);
                    check_field("percent", want.pct, i_out_data[10:4]);
                    check_field("pwm_level", want.pwm, i_out_data[21:11]);
                    check_field("last", want.last, i_out_last);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SCHEDULE_ENABLE: sched_en  = i_cfg_data[0];
                    CFG_FAN_AUTO:        fan_auto  = i_cfg_data[0];
                    CFG_FAN_THRESHOLD:   fan_thr   = i_cfg_data;
                    CFG_FAN_FIXED_POWER: fan_fixed = i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict_levels(i_in_kind, i_in_data);
        end
        o_pending    <= level_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// ===== tb/scheduled_led_dimmer_with_fan_top_tb.sv =====
// ============================================================================
// scheduled_led_dimmer_with_fan_top_tb
// Drives table writes, preview starts and ticks into the dimmer under several
// register settings, with random gaps and output stalls; the checker beside
// the block predicts and compares every LED and fan level.
// ============================================================================
module scheduled_led_dimmer_with_fan_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sldf_pkg::*;

    // kind value that the block has no use for
    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    // generous run limit and the quiet time before a register write / verdict
    localparam int         LIMIT_CYCLES  = 200000;
    localparam int         SETTLE_CYCLES = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = MODE_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_SCHEDULE_ENABLE;
    logic [9:0]  i_cfg_data = '0;

    int          pending;
    int          fail_count;
    int          cycle_cnt = 0;
    int          sink_hold = 0;
    bit          idle_on = 1'b1;

    scheduled_led_dimmer_with_fan_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    scheduled_led_dimmer_with_fan_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_kind    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Bail out if the block hangs or drops results.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stall the output in random bursts; keep it always ready once idling is off.
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            m_axis_tready = 1'b0;
            sink_hold--;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            m_axis_tready = 1'b0;
            sink_hold     = $urandom_range(1, 15) - 1;
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    // tdata layout: time_valid, clock_hour, clock_minute, clock_second,
    // entry_row, entry_channel, entry_value from bit 0 up, zero pad on top.
    function automatic logic [39:0] pack_item(input logic tv, input logic [4:0] hr,
                                              input logic [5:0] mi, input logic [5:0] se,
                                              input logic [4:0] row, input logic [2:0] ch,
                                              input logic [7:0] val);
        return {6'd0, val, ch, row, se, mi, hr, tv};
    endfunction

    function automatic logic [39:0] random_payload();
        return pack_item(1'($urandom_range(0, 7) != 0), 5'($urandom_range(0, 31)),
                         6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                         5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                         8'($urandom_range(0, 255)));
    endfunction

    // Present one item, optionally after an input gap, and hold it until accepted.
    task automatic send_item(input logic [1:0] kind, input logic [39:0] payload);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid = 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = payload;
        s_axis_tuser  = kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic send_write(input logic [4:0] row, input logic [2:0] ch,
                              input logic [7:0] val);
        send_item(MODE_WRITE, pack_item(1'b0, 5'd0, 6'd0, 6'd0, row, ch, val));
    endtask

    task automatic send_tick(input logic tv, input logic [4:0] hr,
                             input logic [5:0] mi, input logic [5:0] se);
        send_item(MODE_TICK, pack_item(tv, hr, mi, se, 5'd0, 3'd0, 8'd0));
    endtask

    // Let every expected level come out, then give a silent item time to finish.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [9:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(input logic sched, input logic auto_fan,
                              input logic [9:0] thr, input logic [6:0] fixed_pwr);
        write_reg(CFG_SCHEDULE_ENABLE, {9'd0, sched});
        write_reg(CFG_FAN_AUTO, {9'd0, auto_fan});
        write_reg(CFG_FAN_THRESHOLD, thr);
        write_reg(CFG_FAN_FIXED_POWER, {3'd0, fixed_pwr});
    endtask

    // A full preview: start it, then walk all 24 hours with random clock content.
    task automatic preview_run();
        send_item(MODE_PREVIEW, random_payload());
        for (int h = 0; h < HOURS; h++)
            send_item(MODE_TICK, random_payload());
    endtask

    // Random mix, mostly well-formed writes and ticks; unused kinds and stray writes do not count.
    task automatic send_mix(input int n);
        int          done;
        int          pick;
        logic [1:0]  kind;
        logic [39:0] payload;
        done = 0;
        while (done < n) begin
            pick    = $urandom_range(0, 99);
            payload = random_payload();
            // keep most writes on real table entries
            if ($urandom_range(0, 9) != 0)
                payload[22:18] = 5'($urandom_range(0, ROWS - 1));
            if ($urandom_range(0, 9) != 0)
                payload[25:23] = 3'($urandom_range(0, CHANNELS - 1));
            if (pick < 50)
                kind = MODE_TICK;
            else if (pick < 92)
                kind = MODE_WRITE;
            else if (pick < 96)
                kind = MODE_PREVIEW;
            else
                kind = MODE_UNUSED;
            send_item(kind, payload);
            if (kind != MODE_UNUSED &&
                !(kind == MODE_WRITE && (payload[22:18] >= ROWS || payload[25:23] >= CHANNELS)))
                done++;
        end
    endtask

    initial begin
        // hold reset, then release it between edges
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Manual mode at reset settings: clamp of manual values, ignored writes,
        // invalid time ignored by manual ticks, unused kind.
        send_write(5'(MANUAL_ROW), 3'd0, 8'd0);
        send_write(5'(MANUAL_ROW), 3'd1, 8'd100);
        send_write(5'(MANUAL_ROW), 3'd2, 8'd101);
        send_write(5'(MANUAL_ROW), 3'd3, 8'd255);
        send_write(5'(MANUAL_ROW), 3'd4, 8'd37);
        send_write(5'(MANUAL_ROW), 3'd5, 8'd9);      // channel beyond the LEDs
        send_write(5'd25, 3'd0, 8'd9);               // row beyond the table
        send_tick(1'b0, 5'd3, 6'd10, 6'd20);
        send_item(MODE_UNUSED, random_payload());
        drain();

        // Schedule mode, fan from load with zero threshold.
        set_config(1'b1, 1'b1, 10'd0, 7'd0);
        send_write(5'd23, 3'd0, 8'd200);             // wrap from hour 23 to hour 0
        send_write(5'd0, 3'd0, 8'd10);
        send_write(5'd0, 3'd1, 8'd255);
        send_write(5'd7, 3'd2, 8'd90);               // falling ramp
        send_write(5'd8, 3'd2, 8'd0);
        send_write(5'd7, 3'd3, 8'd50);               // rising ramp
        send_write(5'd8, 3'd3, 8'd100);
        send_tick(1'b0, 5'd7, 6'd30, 6'd0);          // no valid time: dropped
        send_tick(1'b1, 5'd23, 6'd59, 6'd59);
        send_tick(1'b1, 5'd31, 6'd30, 6'd0);         // hour wraps to 7
        send_tick(1'b1, 5'd7, 6'd63, 6'd63);         // progress past a full hour
        send_tick(1'b1, 5'd0, 6'd0, 6'd0);
        drain();

        // Random phases under varied settings, extremes included.
        set_config(1'b1, 1'b1, 10'd0, 7'd0);
        preview_run();
        send_mix(5);
        drain();

        set_config(1'b1, 1'b1, 10'd800, 7'd100);
        send_mix(15);
        drain();

        // Manual mode with a preview pending: manual ticks must not advance it.
        set_config(1'b0, 1'b0, 10'($urandom_range(0, 800)), 7'd127);
        send_item(MODE_PREVIEW, random_payload());
        send_mix(15);
        drain();

        set_config(1'b1, 1'b0, 10'd1023, 7'd127);
        send_mix(15);
        drain();

        // Final stretch runs at full rate on both sides.
        idle_on = 1'b0;
        set_config(1'b1, 1'b1, 10'($urandom_range(0, 500)), 7'($urandom_range(0, 100)));
        send_mix(15);
        drain();

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sldf_pkg.sv
sv/scheduled_led_dimmer_with_fan_top.sv
tb/scheduled_led_dimmer_with_fan_checker.sv
tb/scheduled_led_dimmer_with_fan_top_tb.sv
